// ===== hw/rtl/dpsm_pkg.sv =====
// shared types and constants of the drive power state machine
`timescale 1ns / 1ps

package dpsm_pkg;

    localparam logic [3:0] ST_START          = 4'd0;
    localparam logic [3:0] ST_NOT_READY      = 4'd1;
    localparam logic [3:0] ST_SOD            = 4'd2;
    localparam logic [3:0] ST_READY          = 4'd3;
    localparam logic [3:0] ST_SWITCHED_ON    = 4'd4;
    localparam logic [3:0] ST_OP_ENABLED     = 4'd5;
    localparam logic [3:0] ST_QUICK_STOP     = 4'd6;
    localparam logic [3:0] ST_FAULT_REACTION = 4'd7;
    localparam logic [3:0] ST_FAULT          = 4'd8;

    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_DISABLE = 3'd1;
    localparam logic [2:0] ACT_ENABLE  = 3'd2;
    localparam logic [2:0] ACT_CLEAR   = 3'd3;
    localparam logic [2:0] ACT_BRAKE   = 3'd4;

    localparam logic       CMD_CONTROL_WORD = 1'b0;
    localparam logic       CMD_POLL         = 1'b1;

    localparam logic [3:0] QS_OPTION_RESET  = 4'd2;
    localparam logic [3:0] QS_OPTION_TO_SOD = 4'd4;

    typedef struct packed {
        logic       setpoint_edge;
        logic       halt_active;
        logic [2:0] drive_action;
        logic [6:0] status_bits;
        logic [3:0] drive_state;
    } result_t;

    typedef struct packed {
        logic [5:0]  pad;
        logic        velocity_zero;
        logic        brake_request;
        logic [15:0] error_code;
        logic [15:0] control_word;
    } item_t;

    function automatic logic [6:0] status_code(input logic [3:0] st);
        logic [6:0] code;
        begin
            unique case (st)
                ST_SOD:            code = 7'h40;
                ST_READY:          code = 7'h21;
                ST_SWITCHED_ON:    code = 7'h23;
                ST_OP_ENABLED:     code = 7'h27;
                ST_QUICK_STOP:     code = 7'h07;
                ST_FAULT_REACTION: code = 7'h0F;
                ST_FAULT:          code = 7'h08;
                default:           code = 7'h00;
            endcase
            return code;
        end
    endfunction

    function automatic logic is_shutdown(input logic [15:0] cw);
        return (cw & 16'h0087) == 16'h0006;
    endfunction

    function automatic logic is_switch_on(input logic [15:0] cw);
        return (cw & 16'h008F) == 16'h0007;
    endfunction

    function automatic logic is_enable_op(input logic [15:0] cw);
        return (cw & 16'h008F) == 16'h000F;
    endfunction

    function automatic logic is_disable_voltage(input logic [15:0] cw);
        return (cw & 16'h0082) == 16'h0000;
    endfunction

    function automatic logic is_quick_stop(input logic [15:0] cw);
        return (cw & 16'h0086) == 16'h0002;
    endfunction

endpackage

// ===== hw/rtl/drive_power_state_machine.sv =====
// drive power state machine: controlword decode, poll steps and result register
`timescale 1ns / 1ps
//
// Usage
//   s_axis carries one item per transfer: tuser is the command (0 controlword
//   event, 1 poll tick), tdata the controlword, error code, brake request and
//   zero-velocity flag. Each accepted item yields exactly one result on
//   m_axis with the new state, its statusword bits, the drive command, the
//   halt latch and the new-set-point edge.
//   The quick stop option is written through cfg_wr_en / cfg_wr_data; the user
//   must write it only while the block is idle, which the block does not enforce.
// Latency and throughput
//   A result is valid the cycle after its item is accepted. The decode is a
//   single combinational pass from the state registers into the result
//   register, so one item is taken every cycle unless a result waits while m_axis_tready is low.
// Reset
//   rst_n clears the state to start, all latches and the pending quick stop,
//   and sets the quick stop option to 2. No result is held after reset.
// Stall
//   While a result waits, a new item is still accepted if m_axis_tready is
//   high in that cycle; otherwise s_axis_tready drops until it is taken.

module drive_power_state_machine
    import dpsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // control_word[15:0], error_code[31:16], brake_request[32], velocity_zero[33]
    input  logic [39:0] s_axis_tdata,
    // command[0]
    input  logic        s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // drive_state[3:0], status_bits[10:4], drive_action[13:11], halt_active[14],
    // setpoint_edge[15]
    output logic [15:0] m_axis_tdata
);

    logic [3:0] state_reg, state_next;
    logic       prev_fault_reset_reg, prev_fault_reset_next;
    logic       prev_setpoint_reg, prev_setpoint_next;
    logic       qs_pending_reg, qs_pending_next;
    logic       halt_reg, halt_next;
    logic [3:0] qs_option_reg;
    logic       out_valid_reg;
    result_t    result_reg, result_next;

    item_t      item;
    logic       in_accept;
    logic       run_pass;
    logic       fr;
    logic       sp;
    logic [2:0] act;
    logic       edge_seen;
    logic       opt_to_sod;

    assign item          = s_axis_tdata;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign fr            = item.control_word[7];
    assign sp            = item.control_word[4];
    assign opt_to_sod    = qs_option_reg <= QS_OPTION_TO_SOD;

    always_comb
    begin
        state_next            = state_reg;
        prev_fault_reset_next = prev_fault_reset_reg;
        prev_setpoint_next    = prev_setpoint_reg;
        qs_pending_next       = qs_pending_reg;
        halt_next             = halt_reg;
        act                   = ACT_NONE;
        edge_seen             = 1'b0;

        run_pass = (s_axis_tuser == CMD_CONTROL_WORD)
                   || (state_reg == ST_OP_ENABLED && item.brake_request);

        // controlword pass, also op-enabled brake polls; blocked while fault reset stays high
        if (run_pass && !(prev_fault_reset_reg && fr))
        begin
            unique case (state_reg)
                ST_START:     state_next = ST_NOT_READY;
                ST_NOT_READY: state_next = ST_SOD;
                ST_SOD:
                begin
                    if (is_shutdown(item.control_word))
                    begin
                        act        = ACT_DISABLE;
                        state_next = ST_READY;
                    end
                end
                ST_READY:
                begin
                    priority if (is_switch_on(item.control_word))
                        state_next = ST_SWITCHED_ON;
                    else if (is_enable_op(item.control_word))
                    begin
                        act        = ACT_ENABLE;
                        state_next = ST_OP_ENABLED;
                    end
                    else if (is_disable_voltage(item.control_word))
                        state_next = ST_SOD;
                    else
                        state_next = state_reg;
                end
                ST_SWITCHED_ON:
                begin
                    priority if (is_enable_op(item.control_word))
                    begin
                        act        = ACT_ENABLE;
                        state_next = ST_OP_ENABLED;
                    end
                    else if (is_shutdown(item.control_word))
                    begin
                        act        = ACT_DISABLE;
                        state_next = ST_READY;
                    end
                    else if (is_disable_voltage(item.control_word))
                        state_next = ST_SOD;
                    else
                        state_next = state_reg;
                end
                ST_OP_ENABLED:
                begin
                    priority if (is_switch_on(item.control_word))
                    begin
                        act        = ACT_DISABLE;
                        state_next = ST_SWITCHED_ON;
                    end
                    else if (is_shutdown(item.control_word))
                    begin
                        act        = ACT_DISABLE;
                        state_next = ST_READY;
                    end
                    else if (is_disable_voltage(item.control_word))
                    begin
                        act        = ACT_DISABLE;
                        state_next = ST_SOD;
                    end
                    else if (is_quick_stop(item.control_word) || item.brake_request)
                        qs_pending_next = 1'b1;
                    else
                        state_next = state_reg;
                end
                ST_QUICK_STOP:
                begin
                    priority if (is_disable_voltage(item.control_word))
                        state_next = ST_SOD;
                    else if (!opt_to_sod && is_enable_op(item.control_word))
                    begin
                        act        = ACT_ENABLE;
                        state_next = ST_OP_ENABLED;
                    end
                    else
                        state_next = state_reg;
                end
                ST_FAULT_REACTION: state_next = ST_FAULT;
                ST_FAULT:
                begin
                    if (fr && !prev_fault_reset_reg)
                    begin
                        act        = ACT_CLEAR;
                        state_next = ST_SOD;
                    end
                end
                default: ;
            endcase

            prev_fault_reset_next = fr;
            halt_next             = item.control_word[8];
            edge_seen             = sp && !prev_setpoint_reg;
            prev_setpoint_next    = sp;
        end

        // poll steps: fault override, automatic chain, pending quick stop
        if (s_axis_tuser == CMD_POLL)
        begin
            if (item.error_code != 16'h0000)
                state_next = ST_FAULT_REACTION;
            if (state_next == ST_START)
                state_next = ST_NOT_READY;
            if (state_next == ST_NOT_READY)
                state_next = ST_SOD;
            if (state_next == ST_FAULT_REACTION)
                state_next = ST_FAULT;
            if (qs_pending_next)
            begin
                act = ACT_BRAKE;
                if (item.velocity_zero)
                begin
                    state_next      = opt_to_sod ? ST_SOD : ST_QUICK_STOP;
                    qs_pending_next = 1'b0;
                end
            end
        end

        result_next.drive_state   = state_next;
        result_next.status_bits   = status_code(state_next);
        result_next.drive_action  = act;
        result_next.halt_active   = halt_next;
        result_next.setpoint_edge = edge_seen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_START;
            prev_fault_reset_reg <= 1'b0;
            prev_setpoint_reg    <= 1'b0;
            qs_pending_reg       <= 1'b0;
            halt_reg             <= 1'b0;
            qs_option_reg        <= QS_OPTION_RESET;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                qs_option_reg <= cfg_wr_data;
            if (in_accept)
            begin
                state_reg            <= state_next;
                prev_fault_reset_reg <= prev_fault_reset_next;
                prev_setpoint_reg    <= prev_setpoint_next;
                qs_pending_reg       <= qs_pending_next;
                halt_reg             <= halt_next;
                out_valid_reg        <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            result_reg <= result_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = result_reg;

    // fault reaction is always passed through within the same item
    a_no_rest_in_fault_reaction: assert property (
        @(posedge clk) disable iff (!rst_n)
        state_reg != ST_FAULT_REACTION
    ) else $error("state register holds fault reaction");

    // result state tracks the state register
    a_result_matches_state: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (result_reg.drive_state == state_reg)
    ) else $error("result state differs from state register");

    // status bits follow the reported state
    a_status_matches_state: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (result_reg.status_bits == status_code(result_reg.drive_state))
    ) else $error("status bits do not match drive state");

    // a poll with a pending quick stop issues the brake
    a_pending_brakes: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_accept && s_axis_tuser == CMD_POLL && qs_pending_reg)
            |=> (m_axis_tvalid && result_reg.drive_action == ACT_BRAKE)
    ) else $error("pending quick stop without brake command");

endmodule
